@@ rtl/core/meq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meq_pkg
// shared types, codes and constants of the mouse event queue
// ----------------------------------------------------------------------------
package meq_pkg;

  // event ring
  localparam int QUEUE_DEPTH = 64;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // cursor
  localparam int          CURSOR_EXTENT = 10;
  localparam logic [11:0] RESET_COL     = 12'd960;
  localparam logic [11:0] RESET_ROW     = 12'd540;
  localparam logic [11:0] POS_MAX       = 12'd4095;

  // configuration registers
  localparam int          CFG_IW   = 2;
  localparam int          CFG_DW   = 13;
  localparam logic [CFG_IW-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_CURSOR_ENABLE = 2'd2;
  localparam logic [12:0] RESET_WIDTH  = 13'd1920;
  localparam logic [12:0] RESET_HEIGHT = 13'd1080;

  // item modes
  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_CENTER = 2'd2;

  // push status codes
  localparam logic [1:0] STATUS_FILTERED = 2'd0;
  localparam logic [1:0] STATUS_QUEUED   = 2'd1;
  localparam logic [1:0] STATUS_DROPPED  = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        report_buttons;
    logic signed [7:0] report_dx;
    logic signed [7:0] report_dy;
  } req_t;

  typedef struct packed {
    logic [1:0]        push_status;
    logic              event_valid;
    logic [7:0]        event_buttons;
    logic signed [7:0] event_dx;
    logic signed [7:0] event_dy;
    logic [11:0]       pos_x;
    logic [11:0]       pos_y;
  } rsp_t;

  typedef struct packed {
    logic [7:0]        buttons;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } event_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH,
    OP_FILTER,
    OP_POP,
    OP_CENTER
  } op_t;

  typedef struct packed {
    op_t    op;
    event_t ev;
  } cmd_t;

endpackage

@@ rtl/core/mouse_event_queue_cursor_tracker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_event_queue_cursor_tracker_top
// mouse report queue with a clamped cursor position
// ----------------------------------------------------------------------------
// req carries one word per push, pop or recenter; rsp returns exactly one
// word per req word, in order. A word moves when its valid is high and its
// stall is low.
// The front filters reports with no motion and unchanged buttons and places
// commands in a two-entry queue; the back owns the 64-slot event ring (63
// usable) in a ram, the cursor and the result register.
// A push, recenter or empty pop passes through the command queue and then the
// result register; a pop that returns an event also passes the registered event
// ram read before the result register.
// Throughput: one word per cycle while rsp_stall is low, except a pop that
// returns an event, which holds the back in the extra ST_POP state.
// The config port (cfg_write, cfg_index, cfg_data) takes a write every cycle
// it is enabled; index 0 screen width, 1 screen height, 2 cursor enable.
// Reset empties the ring, clears the last buttons, puts the cursor at
// (960, 540) and restores a 1920 x 1080 screen with the cursor disabled.
// While rsp_stall is high the result word holds; the back stops after it and
// the front queue fills, then req_stall rises.
// ----------------------------------------------------------------------------
module mouse_event_queue_cursor_tracker_top
  import meq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  meq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  meq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule

@@ rtl/core/meq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meq_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module meq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/meq_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meq_front
// accepts items, filters unchanged reports and queues commands for the back
// ----------------------------------------------------------------------------
module meq_front
  import meq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_take
);

  cmd_t               q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_CW-1:0] count;
  logic [7:0]         prev_buttons;
  cmd_t               cmd_in;
  logic               accept;

  assign req_stall = (count == CMDQ_CW'(CMDQ_DEPTH));
  assign accept    = req_valid && !req_stall;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    cmd_in.ev.buttons = req.report_buttons;
    cmd_in.ev.dx      = req.report_dx;
    cmd_in.ev.dy      = req.report_dy;
    case (req.mode)
      MODE_PUSH: begin
        if (req.report_dx != '0 || req.report_dy != '0 ||
            req.report_buttons != prev_buttons) begin
          cmd_in.op = OP_PUSH;
        end else begin
          cmd_in.op = OP_FILTER;
        end
      end
      MODE_POP:    cmd_in.op = OP_POP;
      MODE_CENTER: cmd_in.op = OP_CENTER;
      default:     cmd_in.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
      prev_buttons <= '0;
    end else begin
      if (accept) begin
        q[wr_ptr] <= cmd_in;
        wr_ptr    <= (wr_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        // last buttons follow every push, even one the ring drops
        if (req.mode == MODE_PUSH) begin
          prev_buttons <= req.report_buttons;
        end
      end
      if (cmd_take) begin
        rd_ptr <= (rd_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (accept && !cmd_take) begin
        count <= count + 1'b1;
      end else if (!accept && cmd_take) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/meq_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meq_back
// event ring, cursor tracking and the result register
// ----------------------------------------------------------------------------
module meq_back
  import meq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_take,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp
);

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  state_t              state;
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW-1:0] wr_ptr_next;
  logic [QUEUE_AW-1:0] rd_ptr_next;
  logic [11:0]         cursor_col;
  logic [11:0]         cursor_row;
  logic [11:0]         col_next;
  logic [11:0]         row_next;
  logic [12:0]         screen_width;
  logic [12:0]         screen_height;
  logic                cursor_enable;
  logic                out_free;
  logic                ring_full;
  logic                ring_empty;
  logic                ram_we;
  event_t              ram_rdata;

  function automatic logic [11:0] axis_move(input logic [11:0] pos,
                                            input logic signed [7:0] delta,
                                            input logic [12:0] size);
    logic signed [14:0] lim;
    logic signed [14:0] p;
    logic [11:0]        lim_c;
    logic [11:0]        res;
    lim = signed'({2'b00, size}) - signed'(15'(CURSOR_EXTENT));
    p   = signed'({3'b000, pos}) + 15'(delta);
    if (lim < 0) begin
      lim_c = '0;
    end else if (lim > signed'({3'b000, POS_MAX})) begin
      lim_c = POS_MAX;
    end else begin
      lim_c = lim[11:0];
    end
    if (p < 0) begin
      res = '0;
    end else if (p > signed'({3'b000, lim_c})) begin
      res = lim_c;
    end else begin
      res = p[11:0];
    end
    return res;
  endfunction

  assign out_free    = !rsp_valid || !rsp_stall;
  assign cmd_take    = cmd_valid && (state == ST_IDLE) && out_free;
  assign wr_ptr_next = (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  // one slot stays empty, so equal pointers mean empty
  assign ring_full   = (wr_ptr_next == rd_ptr);
  assign ring_empty  = (wr_ptr == rd_ptr);
  assign ram_we      = cmd_take && (cmd.op == OP_PUSH) && !ring_full;
  assign col_next    = axis_move(cursor_col, ram_rdata.dx, screen_width);
  assign row_next    = axis_move(cursor_row, ram_rdata.dy, screen_height);

  meq_ram #(
    .WIDTH($bits(event_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr),
    .wdata(cmd.ev),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rsp_valid     <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      cursor_col    <= RESET_COL;
      cursor_row    <= RESET_ROW;
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
      cursor_enable <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          REG_SCREEN_HEIGHT: screen_height <= cfg_data;
          REG_CURSOR_ENABLE: cursor_enable <= cfg_data[0];
          default: ;
        endcase
      end

      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            rsp.push_status   <= STATUS_FILTERED;
            rsp.event_valid   <= 1'b0;
            rsp.event_buttons <= '0;
            rsp.event_dx      <= '0;
            rsp.event_dy      <= '0;
            rsp.pos_x         <= cursor_col;
            rsp.pos_y         <= cursor_row;
            rsp_valid         <= 1'b1;
            case (cmd.op)
              OP_PUSH: begin
                if (ring_full) begin
                  rsp.push_status <= STATUS_DROPPED;
                end else begin
                  rsp.push_status <= STATUS_QUEUED;
                  wr_ptr          <= wr_ptr_next;
                end
              end
              OP_POP: begin
                // ram read of the oldest entry is in flight
                if (!ring_empty) begin
                  rsp_valid <= 1'b0;
                  state     <= ST_POP;
                end
              end
              OP_CENTER: begin
                cursor_col  <= screen_width[12:1];
                cursor_row  <= screen_height[12:1];
                rsp.pos_x   <= screen_width[12:1];
                rsp.pos_y   <= screen_height[12:1];
              end
              default: ;
            endcase
          end
        end
        ST_POP: begin
          rsp.push_status   <= STATUS_FILTERED;
          rsp.event_valid   <= 1'b1;
          rsp.event_buttons <= ram_rdata.buttons;
          rsp.event_dx      <= ram_rdata.dx;
          rsp.event_dy      <= ram_rdata.dy;
          rsp_valid         <= 1'b1;
          rd_ptr            <= rd_ptr_next;
          if (cursor_enable) begin
            cursor_col <= col_next;
            cursor_row <= row_next;
            rsp.pos_x  <= col_next;
            rsp.pos_y  <= row_next;
          end else begin
            rsp.pos_x  <= cursor_col;
            rsp.pos_y  <= cursor_row;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the mouse event queue and cursor tracker
// ----------------------------------------------------------------------------
// Drives push, pop and recenter words through the valid/stall request channel
// and checks every result word against a cycle-free model of the event ring,
// the button filter and the clamped cursor. A short directed sequence is
// followed by random phases with different screen settings and idle patterns
// on both channels.
// ----------------------------------------------------------------------------
module tb;
  import meq_pkg::*;

  localparam logic [1:0] MODE_IDLE      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         RANDOM_PHASES  = 6;
  localparam int         PHASE_WORDS    = 90;
  localparam int         SETTLE_CYCLES  = 8;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  logic              req_valid;
  logic              req_stall;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_stall   = 1'b0;
  rsp_t              rsp;

  int send_idle;
  int recv_idle;
  int quiet_cycles = 0;
  bit filling;
  int run_left;

  // model of the ring, the last buttons and the cursor, plus the pending results
  class cursor_event_checker;
    event_t              ring [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr;
    logic [QUEUE_AW-1:0] rd_ptr;
    logic [7:0]          last_buttons;
    logic [11:0]         col;
    logic [11:0]         row;
    logic [12:0]         width;
    logic [12:0]         height;
    logic                tracking;
    rsp_t                due_results [$];
    int                  mismatches;

    function new();
      wr_ptr       = '0;
      rd_ptr       = '0;
      last_buttons = '0;
      col          = RESET_COL;
      row          = RESET_ROW;
      width        = RESET_WIDTH;
      height       = RESET_HEIGHT;
      tracking     = 1'b0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
      case (idx)
        REG_SCREEN_WIDTH:  width    = d;
        REG_SCREEN_HEIGHT: height   = d;
        REG_CURSOR_ENABLE: tracking = d[0];
        default: ;
      endcase
    endfunction

    // upper bound is screen size minus cursor extent, kept inside 0..4095
    function logic [11:0] clamp_axis(logic [11:0] pos, logic signed [7:0] delta,
                                     logic [12:0] size);
      int lim;
      int p;
      lim = int'(size) - CURSOR_EXTENT;
      p   = int'(pos) + int'(delta);
      if (lim < 0) lim = 0;
      if (lim > int'(POS_MAX)) lim = int'(POS_MAX);
      if (p < 0) p = 0;
      if (p > lim) p = lim;
      return p[11:0];
    endfunction

    function logic [11:0] half_axis(logic [12:0] size);
      logic [12:0] h;
      h = size >> 1;
      return (h > 13'(POS_MAX)) ? POS_MAX : h[11:0];
    endfunction

    function void take_request(req_t w);
      rsp_t                r;
      event_t              e;
      logic [QUEUE_AW-1:0] nxt;
      r = '0;
      case (w.mode)
        MODE_PUSH: begin
          if (w.report_dx != 0 || w.report_dy != 0 || w.report_buttons != last_buttons) begin
            nxt = wr_ptr + 1'b1;
            if (nxt != rd_ptr) begin
              e.buttons = w.report_buttons;
              e.dx      = w.report_dx;
              e.dy      = w.report_dy;
              ring[wr_ptr]  = e;
              wr_ptr        = nxt;
              r.push_status = STATUS_QUEUED;
            end else begin
              r.push_status = STATUS_DROPPED;
            end
            // last buttons follow the report even when it is dropped
            last_buttons = w.report_buttons;
          end else begin
            r.push_status = STATUS_FILTERED;
          end
        end
        MODE_POP: begin
          if (rd_ptr != wr_ptr) begin
            e               = ring[rd_ptr];
            rd_ptr          = rd_ptr + 1'b1;
            r.event_valid   = 1'b1;
            r.event_buttons = e.buttons;
            r.event_dx      = e.dx;
            r.event_dy      = e.dy;
            if (tracking) begin
              col = clamp_axis(col, e.dx, width);
              row = clamp_axis(row, e.dy, height);
            end
          end
        end
        MODE_CENTER: begin
          col = half_axis(width);
          row = half_axis(height);
        end
        default: ;
      endcase
      r.pos_x = col;
      r.pos_y = row;
      due_results.push_back(r);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      bit   bad;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing pending: %p", $realtime, got);
        return;
      end
      want = due_results.pop_front();
      bad = (got.push_status !== want.push_status) ||
            (got.event_valid !== want.event_valid) ||
            (got.event_buttons !== want.event_buttons) ||
            (got.event_dx !== want.event_dx) ||
            (got.event_dy !== want.event_dy) ||
            (got.pos_x !== want.pos_x) ||
            (got.pos_y !== want.pos_y);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected status %0d valid %0d btn %h dx %0d dy %0d pos %0d,%0d",
                   want.push_status, want.event_valid, want.event_buttons,
                   want.event_dx, want.event_dy, want.pos_x, want.pos_y);
          $display("  actual   status %0d valid %0d btn %h dx %0d dy %0d pos %0d,%0d",
                   got.push_status, got.event_valid, got.event_buttons,
                   got.event_dx, got.event_dy, got.pos_x, got.pos_y);
        end
      end
    endfunction
  endclass

  cursor_event_checker queue_sb;

  mouse_event_queue_cursor_tracker_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check accepted words, random stall, watchdog
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) queue_sb.check_result(rsp);
      rsp_stall <= ($urandom_range(99) < recv_idle);
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic put_word(req_t w);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    queue_sb.take_request(w);
  endtask

  task automatic put_fields(logic [1:0] m, logic [7:0] b, logic signed [7:0] x,
                            logic signed [7:0] y);
    req_t w;
    w.mode           = m;
    w.report_buttons = b;
    w.report_dx      = x;
    w.report_dy      = y;
    put_word(w);
  endtask

  task automatic drain_and_settle();
    req_valid <= 1'b0;
    while (queue_sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(logic [12:0] w, logic [12:0] h, logic en);
    logic [CFG_IW-1:0] regs [3] = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_CURSOR_ENABLE};
    logic [CFG_DW-1:0] vals [3];
    vals[0] = w;
    vals[1] = h;
    vals[2] = {12'd0, en};
    for (int i = 0; i < 3; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      queue_sb.write_reg(regs[i], vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [7:0] pick_delta();
    int v;
    v = $urandom_range(6);
    case ($urandom_range(7))
      0, 1, 2: return 8'sd0;
      3:       return 8'sd127;
      4:       return -8'sd128;
      5:       return 8'(v - 3);
      default: return 8'($urandom);
    endcase
  endfunction

  // alternating fill and drain runs so the ring reaches both full and empty
  function automatic req_t make_word();
    req_t w;
    int   roll;
    if (run_left == 0) begin
      filling  = !filling;
      run_left = filling ? $urandom_range(40, 120) : $urandom_range(20, 60);
    end
    run_left--;
    case ($urandom_range(3))
      0, 1:    w.report_buttons = queue_sb.last_buttons;
      2:       w.report_buttons = 8'($urandom);
      default: w.report_buttons = 8'(1 << $urandom_range(7));
    endcase
    w.report_dx = pick_delta();
    w.report_dy = pick_delta();
    roll = $urandom_range(99);
    if (roll < 4) w.mode = MODE_CENTER;
    else if (roll < 6) w.mode = MODE_IDLE;
    else if (roll < (filling ? 18 : 90)) w.mode = MODE_POP;
    else w.mode = MODE_PUSH;
    return w;
  endfunction

  initial begin
    queue_sb  = new();
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_SCREEN_WIDTH;
    cfg_data  = '0;
    req_valid = 1'b0;
    req       = '0;
    send_idle = 15;
    recv_idle = 51;
    filling   = 1'b0;
    run_left  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings, cursor disabled: filter, queue, pops, spare mode, recenter
    put_fields(MODE_PUSH, 8'h00, 8'sd0, 8'sd0);
    put_fields(MODE_PUSH, 8'hff, 8'sd0, 8'sd0);
    put_fields(MODE_PUSH, 8'hff, 8'sd0, 8'sd0);
    put_fields(MODE_PUSH, 8'hff, 8'sd127, -8'sd128);
    put_fields(MODE_PUSH, 8'h00, -8'sd128, 8'sd127);
    put_fields(MODE_PUSH, 8'h00, 8'sd0, 8'sd1);
    put_fields(MODE_POP, 8'hff, -8'sd1, -8'sd1);
    put_fields(MODE_IDLE, 8'ha5, 8'sd90, -8'sd90);
    put_fields(MODE_CENTER, 8'h5a, -8'sd7, 8'sd7);
    put_fields(MODE_POP, 8'h00, 8'sd0, 8'sd0);
    put_fields(MODE_POP, 8'h00, 8'sd0, 8'sd0);
    put_fields(MODE_POP, 8'h00, 8'sd0, 8'sd0);
    put_fields(MODE_POP, 8'h00, 8'sd0, 8'sd0);
    drain_and_settle();

    // cursor enabled on the default screen
    apply_settings(RESET_WIDTH, RESET_HEIGHT, 1'b1);
    put_fields(MODE_PUSH, 8'h01, 8'sd127, 8'sd127);
    put_fields(MODE_PUSH, 8'h02, -8'sd128, -8'sd128);
    put_fields(MODE_PUSH, 8'h02, 8'sd0, 8'sd0);
    put_fields(MODE_PUSH, 8'h00, 8'sd0, -8'sd1);
    put_fields(MODE_POP, 8'h00, 8'sd0, 8'sd0);
    put_fields(MODE_POP, 8'h00, 8'sd0, 8'sd0);
    put_fields(MODE_POP, 8'h00, 8'sd0, 8'sd0);
    put_fields(MODE_CENTER, 8'h00, 8'sd0, 8'sd0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_and_settle();
      case (p)
        0:       apply_settings(13'd16, 13'd16, 1'b1);
        1:       apply_settings(13'd4096, 13'd4096, 1'b1);
        2:       apply_settings(13'd8191, 13'd5, 1'b1);
        3:       apply_settings(13'($urandom_range(16, 4096)),
                                13'($urandom_range(16, 4096)), 1'b0);
        4:       apply_settings(13'd640, 13'd480, 1'b1);
        default: apply_settings(13'($urandom_range(16, 4096)),
                                13'($urandom_range(16, 4096)), 1'b1);
      endcase
      if (p < 2) begin
        send_idle = 15;
        recv_idle = 51;
      end else if (p < 4) begin
        send_idle = 51;
        recv_idle = 15;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      repeat (PHASE_WORDS) put_word(make_word());
    end

    req_valid <= 1'b0;
    while (queue_sb.due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (queue_sb.mismatches == 0 && queue_sb.due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
